// ===== rtl/core/twrqg_pkg.sv =====
// Shared types, constants and codes for the time window run quota gate.
package twrqg_pkg;

  // Table size and the widths that follow from it.
  localparam int NUM_WINDOWS = 16;
  localparam int IDX_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  localparam int CNT_W       = $clog2(NUM_WINDOWS + 1);

  // Day split by reciprocal multiplication. 86400 is 675 shifted left by 7, so the
  // epoch is shifted right by 7 and multiplied by ceil(2^35 / 675); the weekday
  // uses ceil(2^19 / 7) on the day count. Both are exact over their input ranges.
  localparam int          DIV_STEPS        = 2;
  localparam int          STEP_W           = $clog2(DIV_STEPS);
  localparam int          DAY_SHIFT        = 7;
  localparam logic [25:0] DAY_RECIP        = 26'd50903317;
  localparam int          DAY_RECIP_SHIFT  = 35;
  localparam logic [16:0] WEEK_RECIP       = 17'd74899;
  localparam int          WEEK_RECIP_SHIFT = 19;

  localparam int ACTIVE_W = 5;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [STEP_W-1:0] step_t;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_BUMP  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  // Window type codes.
  localparam logic [1:0] WTYPE_ABS  = 2'd0;
  localparam logic [1:0] WTYPE_DAY  = 2'd1;
  localparam logic [1:0] WTYPE_WEEK = 2'd2;
  localparam logic [1:0] WTYPE_BAD  = 2'd3;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_TYPE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry_index;
    logic [1:0]  window_type;
    logic [31:0] window_start;
    logic [31:0] window_stop;
    logic        is_include;
    logic [15:0] run_quota;
    logic [31:0] epoch_seconds;
  } in_item_t;

  typedef struct packed {
    logic time_valid;
    logic quota_blocked;
    logic status;
  } out_item_t;

  // One stored window, without its run counter.
  typedef struct packed {
    logic [1:0]  wtype;
    logic [31:0] start;
    logic [31:0] stop;
    logic        incl;
    logic [15:0] quota;
  } win_entry_t;

  // Controller state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_TIME,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } ctrl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic write_entry;
    logic div_init;
    logic div_step;
    logic time_save;
    logic walk_init;
    logic eval;
    logic result_load;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    kind_t kind;
    logic  div_last;
    logic  walk_more;
    logic  stop_hit;
  } dp_status_t;

endpackage

// ===== rtl/core/twrqg_ifs.sv =====
// Channel interfaces for requests, results and the configuration write.
interface twrqg_req_if (input logic clk);
  logic                 valid;
  logic                 ready;
  twrqg_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twrqg_rsp_if (input logic clk);
  logic                 valid;
  logic                 ready;
  twrqg_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface twrqg_cfg_if (input logic clk);
  logic                                 valid;
  logic                                 ready;
  logic [twrqg_pkg::ACTIVE_W-1:0]       data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/twrqg_ram.sv =====
// Generic single write port RAM with a registered read port.
module twrqg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/twrqg_datapath.sv =====
// Datapath: item register, day split, saved times, window table and result register.
module twrqg_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  twrqg_pkg::dp_cmd_t             cmd,
  output twrqg_pkg::dp_status_t          stat,
  input  twrqg_pkg::in_item_t            req_item,
  input  logic                           cfg_we,
  input  logic [twrqg_pkg::ACTIVE_W-1:0] cfg_data,
  output twrqg_pkg::out_item_t           rsp_item
);

  twrqg_pkg::in_item_t            item;
  logic [twrqg_pkg::ACTIVE_W-1:0] active_windows;
  logic [31:0]                    saved_abs_time;
  logic [16:0]                    saved_day_time;
  logic [19:0]                    saved_week_time;
  logic [15:0]                    day_count;
  logic [16:0]                    div_rem;
  logic [13:0]                    week_q;
  logic [2:0]                     wday_acc;
  twrqg_pkg::step_t               div_step;
  twrqg_pkg::cnt_t                walk_idx;
  logic                           seen_incl;
  logic                           any_in;
  logic                           any_out_excl;
  logic                           blocked;
  twrqg_pkg::out_item_t           result;

  twrqg_pkg::kind_t               kind;
  twrqg_pkg::cnt_t                used_count;
  logic [50:0]                    day_prod;
  logic [31:0]                    day_base;
  logic [31:0]                    rem_full;
  logic [15:0]                    day_plus;
  logic [32:0]                    week_prod;
  logic [15:0]                    wday_full;
  logic [19:0]                    week_base;
  twrqg_pkg::win_entry_t          rd_entry;
  twrqg_pkg::win_entry_t          wr_entry;
  logic [15:0]                    rd_runs;
  logic [31:0]                    entry_time;
  logic                           on_time;
  logic                           quota_nz;
  logic                           stop_now;
  logic                           write_ok;
  logic                           entry_we;
  logic                           runs_we;
  logic [15:0]                    runs_wdata;
  twrqg_pkg::idx_t                waddr;
  twrqg_pkg::out_item_t           result_next;

  assign kind = twrqg_pkg::kind_t'(item.kind);

  // Entries in use, limited to the table size.
  assign used_count = (32'(active_windows) > 32'(twrqg_pkg::NUM_WINDOWS)) ?
                      twrqg_pkg::cnt_t'(twrqg_pkg::NUM_WINDOWS) :
                      twrqg_pkg::cnt_t'(active_windows);

  // Day count of the epoch by reciprocal multiplication.
  assign day_prod = 51'(item.epoch_seconds[31:twrqg_pkg::DAY_SHIFT]) *
                    51'(twrqg_pkg::DAY_RECIP);

  // Seconds into the day, and the weekday of the epoch day.
  assign day_base  = 32'(day_count) * 32'(twrqg_pkg::SECS_PER_DAY);
  assign rem_full  = item.epoch_seconds - day_base;
  assign day_plus  = day_count + 16'(twrqg_pkg::EPOCH_WEEKDAY);
  assign week_prod = 33'(day_plus) * 33'(twrqg_pkg::WEEK_RECIP);
  assign wday_full = day_plus - 16'(week_q) * 16'(twrqg_pkg::DAYS_PER_WEEK);

  // Start of the current week in seconds.
  assign week_base = 20'(wday_acc) * 20'(twrqg_pkg::SECS_PER_DAY);

  // Evaluation of the entry read out of the table.
  always_comb begin
    priority if (rd_entry.wtype == twrqg_pkg::WTYPE_DAY) begin
      entry_time = 32'(saved_day_time);
    end else if (rd_entry.wtype == twrqg_pkg::WTYPE_WEEK) begin
      entry_time = 32'(saved_week_time);
    end else begin
      entry_time = saved_abs_time;
    end
  end

  assign on_time  = (entry_time >= rd_entry.start) && (entry_time <= rd_entry.stop);
  assign quota_nz = rd_entry.quota != 16'd0;
  assign stop_now = (kind == twrqg_pkg::KIND_CHECK) && rd_entry.incl && on_time &&
                    quota_nz && (rd_runs >= rd_entry.quota);

  // Table writes: a window load, or a counter clear or increment during a walk.
  assign write_ok = (item.window_type != twrqg_pkg::WTYPE_BAD) &&
                    (32'(item.entry_index) < 32'(twrqg_pkg::NUM_WINDOWS));
  assign entry_we = cmd.write_entry && write_ok;

  always_comb begin
    runs_we    = 1'b0;
    runs_wdata = 16'd0;
    if (entry_we) begin
      runs_we = 1'b1;
    end else if (cmd.eval) begin
      if (kind == twrqg_pkg::KIND_CHECK) begin
        runs_we = rd_entry.incl && !on_time;
      end else if (kind == twrqg_pkg::KIND_BUMP) begin
        runs_we    = rd_entry.incl && on_time && quota_nz && (rd_runs != 16'hFFFF);
        runs_wdata = rd_runs + 16'd1;
      end
    end
  end

  assign waddr = cmd.write_entry ? twrqg_pkg::idx_t'(item.entry_index) :
                                   walk_idx[twrqg_pkg::IDX_W-1:0];

  assign wr_entry = '{wtype: item.window_type,
                      start: item.window_start,
                      stop:  item.window_stop,
                      incl:  item.is_include,
                      quota: item.run_quota};

  twrqg_ram #(
    .WIDTH ($bits(twrqg_pkg::win_entry_t)),
    .DEPTH (twrqg_pkg::NUM_WINDOWS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (walk_idx[twrqg_pkg::IDX_W-1:0]),
    .rdata (rd_entry)
  );

  twrqg_ram #(
    .WIDTH (16),
    .DEPTH (twrqg_pkg::NUM_WINDOWS)
  ) u_runs_ram (
    .clk   (clk),
    .we    (runs_we),
    .waddr (waddr),
    .wdata (runs_wdata),
    .raddr (walk_idx[twrqg_pkg::IDX_W-1:0]),
    .rdata (rd_runs)
  );

  // Configuration register and saved times.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_windows  <= '0;
      saved_abs_time  <= '0;
      saved_day_time  <= '0;
      saved_week_time <= '0;
    end else begin
      if (cfg_we) begin
        active_windows <= cfg_data;
      end
      if (cmd.time_save) begin
        saved_abs_time  <= item.epoch_seconds;
        saved_day_time  <= div_rem;
        saved_week_time <= 20'(div_rem) + week_base;
      end
    end
  end

  // Item register, day split and walk state. The remainder and the week quotient
  // settle in the first split step, the weekday in the second.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req_item;
    end
    if (cmd.div_init) begin
      day_count <= day_prod[twrqg_pkg::DAY_RECIP_SHIFT +: 16];
      div_step  <= twrqg_pkg::step_t'(twrqg_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      div_rem  <= rem_full[16:0];
      week_q   <= week_prod[twrqg_pkg::WEEK_RECIP_SHIFT +: 14];
      wday_acc <= wday_full[2:0];
      div_step <= div_step - twrqg_pkg::step_t'(1);
    end
    if (cmd.walk_init) begin
      walk_idx     <= '0;
      seen_incl    <= 1'b0;
      any_in       <= 1'b0;
      any_out_excl <= 1'b0;
      blocked      <= 1'b0;
    end else if (cmd.eval) begin
      walk_idx     <= walk_idx + twrqg_pkg::cnt_t'(1);
      seen_incl    <= seen_incl || rd_entry.incl;
      any_in       <= any_in || (rd_entry.incl && on_time);
      any_out_excl <= any_out_excl || (!rd_entry.incl && !on_time);
      blocked      <= stop_now;
    end
  end

  // Result of the current item; only a check reports an outcome.
  assign result_next.time_valid    = (kind == twrqg_pkg::KIND_CHECK) && !blocked &&
                                     (any_in || !seen_incl) && !any_out_excl;
  assign result_next.quota_blocked = (kind == twrqg_pkg::KIND_CHECK) && blocked;
  assign result_next.status        = ((kind == twrqg_pkg::KIND_WRITE) &&
                                      (item.window_type == twrqg_pkg::WTYPE_BAD)) ?
                                     twrqg_pkg::STATUS_BAD_TYPE : twrqg_pkg::STATUS_OK;

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result <= result_next;
    end
  end

  assign rsp_item       = result;
  assign stat.kind      = kind;
  assign stat.div_last  = div_step == '0;
  assign stat.walk_more = walk_idx < used_count;
  assign stat.stop_hit  = stop_now;

endmodule

// ===== rtl/core/twrqg_ctrl.sv =====
// Controller: sequences one item at a time and owns the result valid flag.
module twrqg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  twrqg_pkg::dp_status_t stat,
  output twrqg_pkg::dp_cmd_t    cmd
);

  twrqg_pkg::ctrl_state_t state;
  twrqg_pkg::ctrl_state_t state_next;
  logic                   rsp_valid_next;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twrqg_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      twrqg_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = twrqg_pkg::ST_DISPATCH;
        end
      end
      twrqg_pkg::ST_DISPATCH: begin
        unique case (stat.kind)
          twrqg_pkg::KIND_WRITE: begin
            cmd.write_entry = 1'b1;
            state_next      = twrqg_pkg::ST_FINISH;
          end
          twrqg_pkg::KIND_CHECK: begin
            cmd.div_init = 1'b1;
            state_next   = twrqg_pkg::ST_DIV;
          end
          twrqg_pkg::KIND_BUMP: begin
            cmd.walk_init = 1'b1;
            state_next    = twrqg_pkg::ST_READ;
          end
          twrqg_pkg::KIND_NOP: begin
            state_next = twrqg_pkg::ST_FINISH;
          end
        endcase
      end
      twrqg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = twrqg_pkg::ST_TIME;
        end
      end
      twrqg_pkg::ST_TIME: begin
        cmd.time_save = 1'b1;
        cmd.walk_init = 1'b1;
        state_next    = twrqg_pkg::ST_READ;
      end
      twrqg_pkg::ST_READ: begin
        // The table read for the current entry is under way in this cycle.
        state_next = stat.walk_more ? twrqg_pkg::ST_EVAL : twrqg_pkg::ST_FINISH;
      end
      twrqg_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.stop_hit ? twrqg_pkg::ST_FINISH : twrqg_pkg::ST_READ;
      end
      twrqg_pkg::ST_FINISH: begin
        // Wait until the result register is free or being taken.
        if (!rsp_valid || rsp_ready) begin
          cmd.result_load = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = twrqg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = twrqg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/time_window_run_quota_gate_core.sv =====
// Top level of the time window run quota gate.
//
// Channels: req carries one item (write a window, check a time, bump counters);
// rsp carries one result per item; cfg writes the active window count. All use
// valid and ready, and a transfer happens on a clock edge with both high. cfg
// is always ready; it is to be written only while no item is in flight, which
// the block does not enforce. Items are handled one at a time. A write or a no
// operation goes straight to its result. A check derives day and week seconds
// by reciprocal multiplication, then walks the active windows, as a bump does;
// each window takes a table read state and an evaluate state through the
// single read port of the window table.
// A check that hits a run quota ends its walk at that window.
// The result sits in an output register; req is ready again as soon as the
// result is loaded, so a stalled receiver holds back only the next result.
// Synchronous reset clears the controller, the result valid flag, the active
// window count and the saved times. The window table is not cleared: every
// entry must be written before a walk reaches it.
module time_window_run_quota_gate_core (
  input logic           clk,
  input logic           rst,
  twrqg_req_if.sink     req,
  twrqg_rsp_if.source   rsp,
  twrqg_cfg_if.sink     cfg
);

  twrqg_pkg::dp_cmd_t    cmd;
  twrqg_pkg::dp_status_t stat;

  // The count register takes a write in any cycle.
  assign cfg.ready = 1'b1;

  twrqg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  twrqg_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_item (req.payload),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .rsp_item (rsp.payload)
  );

endmodule

// ===== rtl/core/twrqg_checker.sv =====
// Port-level checks of the gate, bound to the top level.
module twrqg_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic time_valid,
  input logic quota_blocked,
  input logic status
);

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Items are taken one at a time, so a transfer closes the request side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item is in flight");

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(time_valid) && $stable(quota_blocked) && $stable(status)))
    else $error("stalled result changed");

  // A quota block always fails the check.
  a_block_fails: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && quota_blocked) |-> !time_valid)
    else $error("quota blocked result marked valid");

  // A rejected write carries no check outcome.
  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status) |-> (!time_valid && !quota_blocked))
    else $error("error status mixed with check outcome");

endmodule

bind time_window_run_quota_gate_core twrqg_checker u_twrqg_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .time_valid    (rsp.payload.time_valid),
  .quota_blocked (rsp.payload.quota_blocked),
  .status        (rsp.payload.status)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the time window run quota gate core.
module testbench;
  import twrqg_pkg::*;

  // One row of the directed stimulus: the active count to run it under, the
  // request, and a typed-in result where one is obvious.
  typedef struct {
    logic [4:0] active;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  logic clk;
  logic rst;

  twrqg_req_if req_ch (.clk(clk));
  twrqg_rsp_if rsp_ch (.clk(clk));
  twrqg_cfg_if cfg_ch (.clk(clk));

  time_window_run_quota_gate_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Predicted copy of the window table, saved times and active count.
  logic [1:0]  tbl_type  [NUM_WINDOWS];
  logic [31:0] tbl_start [NUM_WINDOWS];
  logic [31:0] tbl_stop  [NUM_WINDOWS];
  logic        tbl_incl  [NUM_WINDOWS];
  logic [15:0] tbl_quota [NUM_WINDOWS];
  logic [15:0] tbl_runs  [NUM_WINDOWS];
  logic [31:0] last_abs;
  logic [16:0] last_day;
  logic [19:0] last_week;
  logic [4:0]  act_count;

  out_item_t   pending [$];
  out_item_t   oldest;
  plan_row_t   plan [$];
  int          errors;
  int          n_items, n_checks, n_passed, n_blocked, n_bumps, n_writes, n_rejected;
  bit          send_gaps, recv_gaps;
  int          hold_left;
  logic [31:0] scene;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // True when window i covers the time of its type that the last check saved.
  function automatic bit window_on(int unsigned i);
    logic [31:0] t;
    case (tbl_type[i])
      WTYPE_DAY:  t = {15'd0, last_day};
      WTYPE_WEEK: t = {12'd0, last_week};
      default:    t = last_abs;
    endcase
    return (t >= tbl_start[i]) && (t <= tbl_stop[i]);
  endfunction

  // Result of one request, with the table and saved times updated on the way.
  function automatic out_item_t gate_predict(in_item_t it);
    out_item_t   r;
    int unsigned n, i, n_incl;
    logic [31:0] days, rem;
    bit          on, any_in, any_excl_out;
    r = '0;
    n = (act_count > NUM_WINDOWS) ? NUM_WINDOWS : act_count;
    case (it.kind)
      KIND_WRITE: begin
        if (it.window_type == WTYPE_BAD) begin
          r.status = STATUS_BAD_TYPE;
        end else begin
          tbl_type[it.entry_index]  = it.window_type;
          tbl_start[it.entry_index] = it.window_start;
          tbl_stop[it.entry_index]  = it.window_stop;
          tbl_incl[it.entry_index]  = it.is_include;
          tbl_quota[it.entry_index] = it.run_quota;
          tbl_runs[it.entry_index]  = '0;
        end
      end
      KIND_CHECK: begin
        days      = it.epoch_seconds / SECS_PER_DAY;
        rem       = it.epoch_seconds % SECS_PER_DAY;
        last_abs  = it.epoch_seconds;
        last_day  = rem[16:0];
        last_week = 20'(((days + EPOCH_WEEKDAY) % DAYS_PER_WEEK) * SECS_PER_DAY + rem);
        n_incl = 0;
        any_in = 1'b0;
        any_excl_out = 1'b0;
        // The walk stops at the first in-time include window that has reached its quota.
        for (i = 0; i < n && !r.quota_blocked; i++) begin
          on = window_on(i);
          if (tbl_incl[i]) begin
            n_incl++;
            if (on && tbl_quota[i] != 0 && tbl_runs[i] >= tbl_quota[i]) begin
              r.quota_blocked = 1'b1;
            end else if (!on) begin
              tbl_runs[i] = '0;
            end else begin
              any_in = 1'b1;
            end
          end else if (!on) begin
            any_excl_out = 1'b1;
          end
        end
        if (!r.quota_blocked) begin
          r.time_valid = (any_in || n_incl == 0) && !any_excl_out;
        end
      end
      KIND_BUMP: begin
        // Counters saturate at their top value.
        for (i = 0; i < n; i++) begin
          if (tbl_incl[i] && tbl_quota[i] != 0 && window_on(i) && tbl_runs[i] != 16'hFFFF) begin
            tbl_runs[i] = tbl_runs[i] + 16'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Directed row builder; want is {time_valid, quota_blocked, status}.
  function automatic plan_row_t mk(logic [4:0] a, kind_t k, logic [3:0] idx, logic [1:0] wt,
                                   logic [31:0] lo, logic [31:0] hi, logic incl,
                                   logic [15:0] quota, logic [31:0] epoch, bit typed,
                                   logic [2:0] want);
    plan_row_t row;
    row.active = a;
    row.item = '{kind: k, entry_index: idx, window_type: wt, window_start: lo,
                 window_stop: hi, is_include: incl, run_quota: quota, epoch_seconds: epoch};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // A random window placed around the scene time, so that checks near the
  // scene time fall both inside and outside it. Every field but the kind gets random bits.
  function automatic in_item_t rand_window(logic [31:0] base);
    in_item_t    it;
    logic [31:0] t, days, rem;
    days = base / SECS_PER_DAY;
    rem  = base % SECS_PER_DAY;
    it.kind = KIND_WRITE;
    it.entry_index = 4'($urandom);
    it.window_type = ($urandom_range(0, 19) == 0) ? WTYPE_BAD : 2'($urandom_range(0, 2));
    case (it.window_type)
      WTYPE_DAY:  t = rem;
      WTYPE_WEEK: t = ((days + EPOCH_WEEKDAY) % DAYS_PER_WEEK) * SECS_PER_DAY + rem;
      default:    t = base;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.window_start = $urandom;
      it.window_stop  = $urandom;
    end else begin
      it.window_start = t - $urandom_range(0, 400);
      it.window_stop  = t + $urandom_range(0, 400);
    end
    it.is_include = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2: it.run_quota = '0;
      9:       it.run_quota = 16'($urandom);
      default: it.run_quota = 16'($urandom_range(1, 4));
    endcase
    it.epoch_seconds = $urandom;
    return it;
  endfunction

  // Random request: mostly checks and bumps near the scene time, some writes and no-ops.
  function automatic in_item_t rand_request(logic [31:0] base);
    in_item_t    it;
    int unsigned sel;
    it  = rand_window(base);
    sel = $urandom_range(0, 99);
    if (sel >= 18) begin
      if (sel < 58) begin
        it.kind = KIND_CHECK;
      end else if (sel < 93) begin
        it.kind = KIND_BUMP;
      end else begin
        it.kind = KIND_NOP;
      end
      case ($urandom_range(0, 9))
        0:       it.epoch_seconds = $urandom;
        1:       it.epoch_seconds = base - $urandom_range(0, 600);
        default: it.epoch_seconds = base + $urandom_range(0, 600);
      endcase
    end
    return it;
  endfunction

  // Send one request and record its expected result at the transfer.
  task automatic push_item(in_item_t it, bit typed, out_item_t want);
    out_item_t r;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.payload <= it;
    req_ch.valid   <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    r = gate_predict(it);
    n_items++;
    case (it.kind)
      KIND_WRITE: begin
        n_writes++;
        n_rejected += r.status;
      end
      KIND_CHECK: begin
        n_checks++;
        n_passed  += r.time_valid;
        n_blocked += r.quota_blocked;
      end
      KIND_BUMP: n_bumps++;
      default: ;
    endcase
    pending.push_back(typed ? want : r);
  endtask

  // Let every outstanding result come back, then a few spare cycles.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the active window count while the block is idle.
  task automatic set_active(logic [4:0] v);
    settle();
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    act_count = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Result ready with random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 17);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result %b with nothing expected", $time, rsp_ch.payload);
        errors++;
      end else begin
        oldest = pending.pop_front();
        if (rsp_ch.payload.time_valid !== oldest.time_valid) begin
          $display("%0t: time_valid expected %b got %b", $time, oldest.time_valid,
                   rsp_ch.payload.time_valid);
          errors++;
        end
        if (rsp_ch.payload.quota_blocked !== oldest.quota_blocked) begin
          $display("%0t: quota_blocked expected %b got %b", $time, oldest.quota_blocked,
                   rsp_ch.payload.quota_blocked);
          errors++;
        end
        if (rsp_ch.payload.status !== oldest.status) begin
          $display("%0t: status expected %b got %b", $time, oldest.status,
                   rsp_ch.payload.status);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [4:0] phase_active [8];
    in_item_t   it;
    int         p, k;

    phase_active = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd5, 5'd16};
    n_items = 0;
    n_checks = 0;
    n_passed = 0;
    n_blocked = 0;
    n_bumps = 0;
    n_writes = 0;
    n_rejected = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    act_count = '0;
    last_abs = '0;
    last_day = '0;
    last_week = '0;
    rst = 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, bad type, bounds, quota block, exclusions.
    plan.push_back(mk(0, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 1, 3'b100));
    plan.push_back(mk(0, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, '1, 1, 3'b100));
    plan.push_back(mk(0, KIND_BUMP, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 1, 3'b000));
    plan.push_back(mk(0, KIND_NOP, '1, WTYPE_BAD, '1, '1, 1, '1, '1, 1, 3'b000));
    plan.push_back(mk(0, KIND_WRITE, 3, WTYPE_BAD, '1, '1, 1, '1, '1, 1, 3'b001));
    plan.push_back(mk(0, KIND_WRITE, 0, WTYPE_ABS, 0, '1, 1, 16'd2, 0, 1, 3'b000));
    plan.push_back(mk(0, KIND_WRITE, 1, WTYPE_DAY, 0, 86399, 0, 0, 0, 1, 3'b000));
    plan.push_back(mk(0, KIND_WRITE, 2, WTYPE_WEEK, 0, 604799, 1, '1, 0, 1, 3'b000));
    plan.push_back(mk(0, KIND_WRITE, 3, WTYPE_ABS, '1, '1, 1, 16'd1, 0, 1, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd1000, 0, 3'b000));
    plan.push_back(mk(4, KIND_BUMP, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 1, 3'b000));
    plan.push_back(mk(4, KIND_BUMP, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 1, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd2000, 0, 3'b000));
    plan.push_back(mk(4, KIND_WRITE, 0, WTYPE_WEEK, 345600, 431999, 1, 0, 0, 1, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 0, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd259200, 0, 3'b000));
    plan.push_back(mk(4, KIND_WRITE, 1, WTYPE_DAY, 3600, 7199, 0, 0, 0, 1, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 0, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, '1, 0, 3'b000));
    plan.push_back(mk(4, KIND_BUMP, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd0, 1, 3'b000));
    plan.push_back(mk(4, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, '1, 0, 3'b000));
    plan.push_back(mk(0, KIND_CHECK, 0, WTYPE_ABS, 0, 0, 0, 0, 32'd1000, 1, 3'b100));
    foreach (plan[k]) begin
      if (plan[k].active != act_count) begin
        set_active(plan[k].active);
      end
      push_item(plan[k].item, plan[k].typed, plan[k].want);
    end

    // Run quota: one always-open window with a quota of three is bumped past
    // its quota; the final check must be blocked.
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    set_active(5'd1);
    it = '{kind: KIND_WRITE, entry_index: 0, window_type: WTYPE_ABS, window_start: 0,
           window_stop: '1, is_include: 1, run_quota: 16'd3, epoch_seconds: 0};
    push_item(it, 1'b0, '0);
    it.kind = KIND_CHECK;
    it.epoch_seconds = 32'd5;
    push_item(it, 1'b0, '0);
    it.kind = KIND_BUMP;
    repeat (5) push_item(it, 1'b0, '0);
    it.kind = KIND_CHECK;
    push_item(it, 1'b0, '0);

    // Random phases: refill the whole table around a new scene time, set the
    // active count, then a mix of checks, bumps, writes and no-ops.
    for (p = 0; p < 8; p++) begin
      send_gaps = (p != 7) && ($urandom_range(0, 3) != 0);
      recv_gaps = (p != 7) && ($urandom_range(0, 3) != 0);
      scene = ($urandom_range(0, 2) == 0) ? ($urandom % 49710) * SECS_PER_DAY : $urandom;
      for (k = 0; k < NUM_WINDOWS; k++) begin
        it = rand_window(scene);
        it.entry_index = 4'(k);
        it.window_type = 2'($urandom_range(0, 2));
        push_item(it, 1'b0, '0);
      end
      set_active(phase_active[p]);
      repeat (93) push_item(rand_request(scene), 1'b0, '0);
    end

    // Drain and finish.
    req_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("testbench: %0d requests: %0d checks (%0d in time, %0d quota blocked), %0d bumps",
             n_items, n_checks, n_passed, n_blocked, n_bumps);
    $display("testbench: %0d window writes with %0d bad types, active counts 0 to 31",
             n_writes, n_rejected);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
